[hdl/lftx_pkg.sv]
// Package for the LANC frame transceiver: phase, register index and mode
// codes, command bytes, reset values and the shared structs.
// No dependencies.
package lftx_pkg;

  localparam int unsigned FrameBytesDef = 8;
  localparam int unsigned TxBytesDef    = 4;

  localparam logic [7:0]  PREFIX_BYTE     = 8'h28;
  localparam logic [7:0]  CODE_FOCUS_FAR  = 8'h45;
  localparam logic [7:0]  CODE_FOCUS_NEAR = 8'h47;
  localparam logic [7:0]  CODE_AUTOFOCUS  = 8'h41;
  localparam logic [7:0]  ZOOM_OUT_FLAG   = 8'h10;
  localparam logic [7:0]  FILL_BYTE       = 8'hFF;
  localparam logic [7:0]  CLEAR_BYTE      = 8'h00;

  localparam logic [9:0]  BIT_TIME_RST    = 10'd104;
  localparam logic [9:0]  BIT_TIME_MIN    = 10'd2;
  localparam logic [15:0] SYNC_IDLE_RST   = 16'd3000;
  localparam logic [15:0] SYNC_IDLE_MIN   = 16'd1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE      = 2'd0,
    REG_ZOOM      = 2'd1,
    REG_BIT_TIME  = 2'd2,
    REG_SYNC_IDLE = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_UNTOUCHED  = 3'd0,
    MODE_CLEARED    = 3'd1,
    MODE_ZOOM       = 3'd2,
    MODE_FOCUS_FAR  = 3'd3,
    MODE_FOCUS_NEAR = 3'd4,
    MODE_AUTOFOCUS  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_WAIT = 2'd1,
    PH_BYTE = 2'd2,
    PH_GAP  = 2'd3
  } phase_e;

  // Effective settings seen by the frame engine
  typedef struct packed {
    logic [9:0]  bit_time;
    logic [9:0]  half_bit;
    logic [15:0] sync_idle;
    logic [7:0]  cmd_byte0;
    logic [7:0]  cmd_byte1;
  } cfg_t;

  typedef struct packed {
    logic       drive_level;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [1:0] byte_slot;
    logic       frame_last;
  } result_t;

endpackage

[hdl/lftx_in_if.sv]
// Input channel of the LANC frame transceiver: one sampled line level per tick.
// Standalone; no package needed.
interface lftx_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink   (input valid, input line_level, output ready);
endinterface

[hdl/lftx_out_if.sv]
// Result channel of the LANC frame transceiver: drive level and received bytes.
// Standalone; no package needed.
interface lftx_out_if;
  logic       valid;
  logic       ready;
  logic       drive_level;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [1:0] byte_slot;
  logic       frame_last;

  modport source (output valid, output drive_level, output byte_valid, output byte_value,
                  output byte_slot, output frame_last, input ready);
  modport sink   (input valid, input drive_level, input byte_valid, input byte_value,
                  input byte_slot, input frame_last, output ready);
endinterface

[hdl/lanc_frame_transceiver_top.sv]
// LANC frame transceiver, top level. A tick request waits in the input register and its
// result in the result register. Throughput: 1 tick request per cycle while the result
// is taken; the frame engine steps once per tick. A tick request is taken even while a
// result waits: the input register holds it. Reset (async, active low): sync phase,
// counters and shift clear, drive low, registers to mode 0, zoom 0, bit time 104, idle
// gap 3000. Depends on lftx_pkg, lftx_in_if, lftx_out_if, lftx_cfg and lftx_core.
module lanc_frame_transceiver_top import lftx_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FrameBytesDef,
  parameter int unsigned TX_BYTES    = TxBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lftx_in_if.sink             in_i,
  lftx_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  result_t res;

  // Input register: one sampled line level waiting for the engine
  logic    in_valid_q;
  logic    in_line_q;
  // Result register
  logic    out_valid_q;
  result_t out_q;
  logic    step;

  // Advance the engine when a tick is held and the result slot is free or draining
  assign step     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  lftx_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lftx_core #(
    .FRAME_BYTES (FRAME_BYTES),
    .TX_BYTES    (TX_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .line_i (in_line_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Hold the tick until the engine takes it; load a new one when the slot frees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_line_q <= in_i.line_level;
  end

  // Capture the engine's result; drop it once taken downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= res;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_level = out_q.drive_level;
  assign out_o.byte_valid  = out_q.byte_valid;
  assign out_o.byte_value  = out_q.byte_value;
  assign out_o.byte_slot   = out_q.byte_slot;
  assign out_o.frame_last  = out_q.frame_last;

endmodule

[hdl/lftx_cfg.sv]
// Configuration registers of the LANC frame transceiver and the derived
// command bytes and effective timing. Depends on lftx_pkg.
module lftx_cfg import lftx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  logic [2:0]  mode_q;
  logic [4:0]  zoom_q;
  logic [9:0]  bit_time_q;
  logic [15:0] sync_idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 3'(MODE_UNTOUCHED);
      zoom_q      <= 5'd0;
      bit_time_q  <= BIT_TIME_RST;
      sync_idle_q <= SYNC_IDLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:      mode_q      <= cfg_wdata_i[2:0];
        REG_ZOOM:      zoom_q      <= cfg_wdata_i[4:0];
        REG_BIT_TIME:  bit_time_q  <= cfg_wdata_i[9:0];
        REG_SYNC_IDLE: sync_idle_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Zoom code: magnitude saturated to 8, sign selects zoom-out flag
  logic       zoom_neg;
  logic [4:0] zoom_mag_raw;
  logic [3:0] zoom_mag;
  logic [2:0] zoom_mag_m1;
  logic [7:0] zoom_code;
  logic [9:0] bit_eff;

  always_comb begin
    zoom_neg     = zoom_q[4];
    zoom_mag_raw = zoom_neg ? (~zoom_q + 5'd1) : zoom_q;
    zoom_mag     = (zoom_mag_raw > 5'd8) ? 4'd8 : zoom_mag_raw[3:0];
    zoom_mag_m1  = 3'(zoom_mag - 4'd1);
    zoom_code    = {4'b0000, zoom_mag_m1, 1'b0} | (zoom_neg ? ZOOM_OUT_FLAG : 8'h00);
  end

  always_comb begin
    bit_eff         = (bit_time_q < BIT_TIME_MIN) ? BIT_TIME_MIN : bit_time_q;
    cfg_o.bit_time  = bit_eff;
    cfg_o.half_bit  = {1'b0, bit_eff[9:1]};
    cfg_o.sync_idle = (sync_idle_q == 16'd0) ? SYNC_IDLE_MIN : sync_idle_q;
    case (mode_q)
      MODE_CLEARED: begin
        cfg_o.cmd_byte0 = CLEAR_BYTE;
        cfg_o.cmd_byte1 = CLEAR_BYTE;
      end
      MODE_ZOOM: begin
        cfg_o.cmd_byte0 = (zoom_mag == 4'd0) ? CLEAR_BYTE : PREFIX_BYTE;
        cfg_o.cmd_byte1 = (zoom_mag == 4'd0) ? CLEAR_BYTE : zoom_code;
      end
      MODE_FOCUS_FAR: begin
        cfg_o.cmd_byte0 = PREFIX_BYTE;
        cfg_o.cmd_byte1 = CODE_FOCUS_FAR;
      end
      MODE_FOCUS_NEAR: begin
        cfg_o.cmd_byte0 = PREFIX_BYTE;
        cfg_o.cmd_byte1 = CODE_FOCUS_NEAR;
      end
      MODE_AUTOFOCUS: begin
        cfg_o.cmd_byte0 = PREFIX_BYTE;
        cfg_o.cmd_byte1 = CODE_AUTOFOCUS;
      end
      default: begin
        cfg_o.cmd_byte0 = FILL_BYTE;
        cfg_o.cmd_byte1 = FILL_BYTE;
      end
    endcase
  end

endmodule

[hdl/lftx_core.sv]
// Frame engine of the LANC frame transceiver: sync, bit timing, transmit and
// receive shifting for one tick per step. Depends on lftx_pkg.
module lftx_core import lftx_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FrameBytesDef,
  parameter int unsigned TX_BYTES    = TxBytesDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    line_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  localparam int unsigned BYTE_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [BYTE_W-1:0] TX_B   = BYTE_W'(TX_BYTES);
  localparam logic [BYTE_W-1:0] LAST_B = BYTE_W'(FRAME_BYTES - 1);

  phase_e            phase_q, phase_d;
  logic [15:0]       tick_q, tick_d;
  logic [9:0]        sub_q, sub_d;
  logic [3:0]        slot_q, slot_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [7:0]        shift_q, shift_d;
  logic              drive_q, drive_d;

  // Bit timing inside a byte: slot counts whole bits, sub the ticks within it
  logic        is_tx, is_last;
  logic [9:0]  sub_inc;
  logic        wrap, byte_end, tx_evt, rx_evt;
  logic [2:0]  rx_bit;
  logic [15:0] tick_sat;
  logic [15:0] tick_inc;
  logic [7:0]  tx_load;
  logic [7:0]  slot_diff;

  always_comb begin
    is_tx     = byte_q < TX_B;
    is_last   = byte_q == LAST_B;
    sub_inc   = sub_q + 10'd1;
    wrap      = sub_inc == cfg_i.bit_time;
    byte_end  = wrap && (slot_q == 4'd8);
    tx_evt    = wrap && !byte_end;
    rx_evt    = !wrap && (sub_inc == cfg_i.half_bit) && (slot_q != 4'd0);
    rx_bit    = 3'(slot_q - 4'd1);
    tick_inc  = tick_q + 16'd1;
    tick_sat  = (tick_q == 16'hFFFF) ? tick_q : tick_inc;
    slot_diff = 8'(byte_q) - 8'(TX_BYTES);
    if (!is_tx) begin
      tx_load = 8'h00;
    end else if (byte_q == BYTE_W'(0)) begin
      tx_load = cfg_i.cmd_byte0;
    end else if (byte_q == BYTE_W'(1)) begin
      tx_load = cfg_i.cmd_byte1;
    end else begin
      tx_load = FILL_BYTE;
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    sub_d   = sub_q;
    slot_d  = slot_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    drive_d = drive_q;
    case (phase_q)
      PH_SYNC: begin
        if (!line_i) begin
          tick_d = 16'd0;
        end else if (tick_sat >= cfg_i.sync_idle) begin
          phase_d = PH_WAIT;
          tick_d  = 16'd0;
        end else begin
          tick_d = tick_sat;
        end
      end
      PH_WAIT: begin
        if (!line_i) begin
          phase_d = PH_BYTE;
          tick_d  = 16'd0;
          sub_d   = 10'd0;
          slot_d  = 4'd0;
          shift_d = tx_load;
        end
      end
      PH_BYTE: begin
        sub_d  = wrap ? 10'd0 : sub_inc;
        slot_d = wrap ? slot_q + 4'd1 : slot_q;
        if (byte_end) begin
          drive_d = 1'b0;
          tick_d  = 16'd0;
          if (is_last) begin
            byte_d  = '0;
            phase_d = PH_SYNC;
          end else begin
            byte_d  = byte_q + BYTE_W'(1);
            phase_d = PH_GAP;
          end
        end else if (is_tx) begin
          if (tx_evt) drive_d = shift_q[slot_q[2:0]];
        end else if (rx_evt && line_i) begin
          shift_d[rx_bit] = 1'b1;
        end
      end
      PH_GAP: begin
        if (tick_inc >= 16'(cfg_i.half_bit)) begin
          phase_d = PH_WAIT;
          tick_d  = 16'd0;
        end else begin
          tick_d = tick_inc;
        end
      end
      default: phase_d = PH_SYNC;
    endcase
  end

  // Result of this tick
  always_comb begin
    res_o             = '0;
    res_o.drive_level = drive_d;
    if (phase_q == PH_BYTE && byte_end && !is_tx) begin
      res_o.byte_valid = 1'b1;
      res_o.byte_value = shift_q;
      res_o.byte_slot  = slot_diff[1:0];
      res_o.frame_last = is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC;
      tick_q  <= 16'd0;
      sub_q   <= 10'd0;
      slot_q  <= 4'd0;
      byte_q  <= '0;
      shift_q <= 8'h00;
      drive_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      sub_q   <= sub_d;
      slot_q  <= slot_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      drive_q <= drive_d;
    end
  end

endmodule
